[design/cdsd_pkg.sv]
package cdsd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 5;
  localparam int EXT_W        = (CNT_W > CH_W + 1) ? CNT_W : CH_W + 1;
  localparam int RSSI_W       = 9;
  localparam int TIME_W       = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESH      = 3'd0,
    REG_CARRIER_MIN = 3'd1,
    REG_GRACE       = 3'd2,
    REG_DWELL       = 3'd3,
    REG_STATUS_IVL  = 3'd4,
    REG_CH_COUNT    = 3'd5
  } cfg_reg_t;

  localparam logic signed [RSSI_W-1:0] THRESH_RST      = -9'sd70;
  localparam logic        [TIME_W-1:0] CARRIER_MIN_RST = 32'd5000;
  localparam logic        [TIME_W-1:0] GRACE_RST       = 32'd1000;
  localparam logic        [TIME_W-1:0] DWELL_RST       = 32'd500;
  localparam logic        [TIME_W-1:0] STATUS_IVL_RST  = 32'd300;
  localparam logic        [CNT_W-1:0]  CH_COUNT_RST    = 5'd1;

  typedef struct packed {
    logic signed [RSSI_W-1:0] thresh;
    logic        [TIME_W-1:0] carrier_min;
    logic        [TIME_W-1:0] grace;
    logic        [TIME_W-1:0] dwell;
    logic        [TIME_W-1:0] status_ivl;
    logic        [CNT_W-1:0]  ch_count;
  } cfg_t;

  typedef struct packed {
    logic signed [RSSI_W-1:0] rssi;
    logic        [TIME_W-1:0] now;
  } sample_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              signal_present;
    logic              carrier_alarm;
    logic [TIME_W-1:0] alarm_duration;
    logic              status_due;
    logic              hop;
    logic [CH_W-1:0]   next_channel;
  } result_t;

endpackage

[design/cdsd_cfg.sv]
module cdsd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cdsd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cdsd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cdsd_pkg::cfg_t                   cfg
);
  import cdsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thresh      <= THRESH_RST;
      cfg.carrier_min <= CARRIER_MIN_RST;
      cfg.grace       <= GRACE_RST;
      cfg.dwell       <= DWELL_RST;
      cfg.status_ivl  <= STATUS_IVL_RST;
      cfg.ch_count    <= CH_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_THRESH:      cfg.thresh      <= cfg_wdata[RSSI_W-1:0];
        REG_CARRIER_MIN: cfg.carrier_min <= cfg_wdata[TIME_W-1:0];
        REG_GRACE:       cfg.grace       <= cfg_wdata[TIME_W-1:0];
        REG_DWELL:       cfg.dwell       <= cfg_wdata[TIME_W-1:0];
        REG_STATUS_IVL:  cfg.status_ivl  <= cfg_wdata[TIME_W-1:0];
        REG_CH_COUNT:    cfg.ch_count    <= cfg_wdata[CNT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

[design/cdsd_track.sv]
module cdsd_track (
  input  logic              clk,
  input  logic              rst,
  input  cdsd_pkg::cfg_t    cfg,
  input  cdsd_pkg::sample_t smp,
  input  logic              adv,
  output cdsd_pkg::result_t res
);
  import cdsd_pkg::*;

  logic [CH_W-1:0]   channel_index, channel_index_next;
  logic [TIME_W-1:0] channel_entered_at, channel_entered_at_next;
  logic [TIME_W-1:0] above_since, above_since_next;
  logic              above_valid, above_valid_next;
  logic              flagged, flagged_next;
  logic [TIME_W-1:0] last_status_at, last_status_at_next;

  logic              above;
  logic [TIME_W-1:0] since_eff;
  logic [TIME_W-1:0] dur;
  logic              alarm;
  logic              flag_mid;
  logic [TIME_W-1:0] status_gap;
  logic              status;
  logic [TIME_W:0]   limit;
  logic [TIME_W-1:0] dwell_gap;
  logic              hop;
  logic [EXT_W-1:0]  cnt_eff;
  logic [EXT_W-1:0]  nxt;
  logic [CH_W-1:0]   hop_target;

  always_comb begin
    above      = smp.rssi > cfg.thresh;
    since_eff  = above_valid ? above_since : smp.now;
    dur        = smp.now - since_eff;
    alarm      = above && !flagged && (dur >= cfg.carrier_min);
    flag_mid   = flagged | alarm;

    status_gap = smp.now - last_status_at;
    status     = !flag_mid && (status_gap > cfg.status_ivl);

    // dwell stretch while present, summed without wrap
    limit      = above ? ({1'b0, cfg.carrier_min} + {1'b0, cfg.grace})
                       : {1'b0, cfg.dwell};
    dwell_gap  = smp.now - channel_entered_at;
    hop        = {1'b0, dwell_gap} > limit;

    cnt_eff = EXT_W'(cfg.ch_count);
    if (cnt_eff == '0) begin
      cnt_eff = EXT_W'(1);
    end else if (cnt_eff > EXT_W'(MAX_CHANNELS)) begin
      cnt_eff = EXT_W'(MAX_CHANNELS);
    end
    nxt        = EXT_W'(channel_index) + EXT_W'(1);
    hop_target = (nxt >= cnt_eff) ? '0 : nxt[CH_W-1:0];

    channel_index_next      = hop ? hop_target : channel_index;
    channel_entered_at_next = hop ? smp.now : channel_entered_at;
    above_since_next        = (above && !above_valid) ? smp.now : above_since;
    above_valid_next        = above && !hop;
    flagged_next            = flag_mid && !hop;
    last_status_at_next     = status ? smp.now : last_status_at;

    res.channel        = channel_index;
    res.signal_present = above;
    res.carrier_alarm  = alarm;
    res.alarm_duration = alarm ? dur : '0;
    res.status_due     = status;
    res.hop            = hop;
    res.next_channel   = channel_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index      <= '0;
      channel_entered_at <= '0;
      above_since        <= '0;
      above_valid        <= 1'b0;
      flagged            <= 1'b0;
      last_status_at     <= '0;
    end else if (adv) begin
      channel_index      <= channel_index_next;
      channel_entered_at <= channel_entered_at_next;
      above_since        <= above_since_next;
      above_valid        <= above_valid_next;
      flagged            <= flagged_next;
      last_status_at     <= last_status_at_next;
    end
  end

  a_alarm_needs_signal: assert property (@(posedge clk) disable iff (rst)
    adv && res.carrier_alarm |-> res.signal_present)
    else $error("alarm without signal present");

  a_duration_zero: assert property (@(posedge clk) disable iff (rst)
    adv && !res.carrier_alarm |-> res.alarm_duration == '0)
    else $error("alarm duration set without alarm");

  a_no_status_on_alarm: assert property (@(posedge clk) disable iff (rst)
    adv |-> !(res.carrier_alarm && res.status_due))
    else $error("status event together with alarm");

  a_hop_clears: assert property (@(posedge clk) disable iff (rst)
    adv && res.hop |=> !flagged && !above_valid)
    else $error("hop left alarm or timer state set");

  a_channel_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(channel_index))
    else $error("channel changed without a sample");

endmodule

[design/carrier_dwell_scan_detector.sv]
// A sample sits in the input register, then loads the result register; the result is
// valid once it is in the result register, and state updates with that load.
// Throughput: one sample per cycle; out_ready low stalls the input side only once
// both the input and result registers are full.
// Reset (rst, synchronous): clears channel, timers, alarm and valid flags and loads
// the register defaults.
module carrier_dwell_scan_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [cdsd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [cdsd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [cdsd_pkg::RSSI_W-1:0]     rssi_dbm,
  input  logic [cdsd_pkg::TIME_W-1:0]            now_ms,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [cdsd_pkg::CH_W-1:0]              channel,
  output logic                                   signal_present,
  output logic                                   carrier_alarm,
  output logic [cdsd_pkg::TIME_W-1:0]            alarm_duration_ms,
  output logic                                   status_due,
  output logic                                   hop,
  output logic [cdsd_pkg::CH_W-1:0]              next_channel
);
  import cdsd_pkg::*;

  cfg_t    cfg;
  sample_t s1;
  logic    s1_valid;
  result_t res;
  result_t out_res;
  logic    out_load;
  logic    adv;

  cdsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cdsd_track u_track (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .smp (s1),
    .adv (adv),
    .res (res)
  );

  assign out_load = !out_valid || out_ready;
  assign adv      = s1_valid && out_load;
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers: load on transfer only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1.rssi <= rssi_dbm;
      s1.now  <= now_ms;
    end
    if (adv) begin
      out_res <= res;
    end
  end

  assign channel           = out_res.channel;
  assign signal_present    = out_res.signal_present;
  assign carrier_alarm     = out_res.carrier_alarm;
  assign alarm_duration_ms = out_res.alarm_duration;
  assign status_due        = out_res.status_due;
  assign hop               = out_res.hop;
  assign next_channel      = out_res.next_channel;

endmodule
